// File: hw/rtl/kse_pkg.sv
// kse_pkg: shared types, request codes and keymap for the keypad scanner
// with event queue; used by kse_scan, kse_fifo and the top level
`timescale 1ns / 1ps

package kse_pkg;

   // request codes
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_SAMPLE = 2'd1;
   localparam logic [1:0] REQ_POP    = 2'd2;

   // default queue depth, one entry always left free
   localparam int QUEUE_DEPTH_DEF = 32;

   // column register value while no column is driven
   localparam logic [2:0] NO_COLUMN = 3'd4;

   // characters indexed by column*4+row, first character at index 0
   localparam logic [127:0] KEY_MAP = "DCBA#9630852*741";

   // one event headed for the queue
   typedef struct packed {
      logic       valid;
      logic       pressed;
      logic [7:0] chr;
   } kse_push_type;

   // ascii code of the key at matrix index idx
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [6:0] base;
      base = {~idx, 3'b000};
      return KEY_MAP[base +: 8];
   endfunction

endpackage

// File: hw/rtl/kse_scan.sv
// kse_scan: column counter and pressed marks, walks one row a cycle on a sample
// depends on kse_pkg
`timescale 1ns / 1ps

module kse_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_tick,
   input  logic                 start_sample,
   input  logic [3:0]           rows,
   output logic                 busy,
   output logic [3:0]           col_drive_next,
   output kse_pkg::kse_push_type push
);
   import kse_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } scan_state_type;

   scan_state_type state_ff, state_in;
   logic [2:0]     col_ff, col_in;
   logic [1:0]     row_ff, row_in;
   logic [3:0]     rows_ff;
   logic [15:0]    key_down_ff, key_down_in;
   logic [3:0]     key_idx;
   logic           level;

   // current matrix position and sampled level
   assign key_idx = {col_ff[1:0], row_ff};
   assign level   = rows_ff[row_ff];

   // column advance on a tick, with wrap
   always_comb begin
      col_in = col_ff;
      if (start_tick) begin
         col_in = (col_ff >= 3'd3) ? 3'd0 : col_ff + 3'd1;
      end
   end

   // one-hot drive after this request, all zero while no column is driven
   assign col_drive_next = col_in[2] ? 4'b0000 : (4'b0001 << col_in[1:0]);

   // scan sequencer
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      key_down_in = key_down_ff;
      push.valid   = 1'b0;
      push.pressed = level;
      push.chr     = key_char(key_idx);
      case (state_ff)
         ST_IDLE: begin
            if (start_sample && !col_ff[2]) begin
               state_in = ST_SCAN;
               row_in   = 2'd0;
            end
         end
         ST_SCAN: begin
            if (level != key_down_ff[key_idx]) begin
               key_down_in[key_idx] = level;
               push.valid           = 1'b1;
            end
            row_in = row_ff + 2'd1;
            if (row_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == ST_SCAN);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         col_ff      <= NO_COLUMN;
         row_ff      <= 2'd0;
         key_down_ff <= '0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         key_down_ff <= key_down_in;
      end
   end

   // sampled row levels
   always_ff @(posedge clock) begin
      if (start_sample) begin
         rows_ff <= rows;
      end
   end

endmodule

// File: hw/rtl/kse_fifo.sv
// kse_fifo: ring queue of key events in a synchronous memory, registered read
// depends on kse_pkg
`timescale 1ns / 1ps

module kse_fifo #(
   parameter int QUEUE_DEPTH = kse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kse_pkg::kse_push_type push,
   input  logic                  pop_go,
   output logic                  pop_hit,
   output logic                  rd_pressed,
   output logic [7:0]            rd_char
);
   import kse_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

   logic [8:0]    mem [QUEUE_DEPTH];
   logic [8:0]    rdata_ff;
   logic [AW-1:0] wp_ff, wp_in, wp_next;
   logic [AW-1:0] rp_ff, rp_in, rp_next;
   logic          wr_en;

   // wrapped successors
   assign wp_next = (wp_ff == LAST) ? '0 : wp_ff + AW'(1);
   assign rp_next = (rp_ff == LAST) ? '0 : rp_ff + AW'(1);

   // push dropped when the queue is full
   assign wr_en   = push.valid && (wp_next != rp_ff);
   assign pop_hit = (wp_ff != rp_ff);

   // pointer updates
   always_comb begin
      wp_in = wr_en ? wp_next : wp_ff;
      rp_in = (pop_go && pop_hit) ? rp_next : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   // event store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= {push.pressed, push.chr};
      end
   end

   // event store read port, data held until the next pop
   always_ff @(posedge clock) begin
      if (pop_go && pop_hit) begin
         rdata_ff <= mem[rp_ff];
      end
   end

   assign rd_pressed = rdata_ff[8];
   assign rd_char    = rdata_ff[7:0];

endmodule

// File: hw/rtl/keypad_scanner_event_fifo.sv
// keypad_scanner_event_fifo: 4x4 keypad scanner with a queue of press/release events.
// Each response is registered in the read stage, then in the output register.
// Throughput: ticks and pops one per cycle while the response path does not stall;
// a row sample with a driven column holds req_ready low while the scan unit walks
// the rows, with at most one event store write per row.
// Reset clears column, pressed marks and queue pointers; store contents are not cleared.
`timescale 1ns / 1ps

module keypad_scanner_event_fifo #(
   parameter int QUEUE_DEPTH = kse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [3:0] req_rows,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_col_drive,
   output logic       rsp_pop_valid,
   output logic       rsp_event_pressed,
   output logic [7:0] rsp_event_char
);
   import kse_pkg::*;

   kse_push_type push;
   logic         accept, s1_adv, busy;
   logic         is_tick, is_sample, is_pop, pop_hit;
   logic [3:0]   col_drive_next;
   logic         rd_pressed;
   logic [7:0]   rd_char;
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_hit_ff;
   logic [3:0]   s1_drive_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [3:0]   rsp_drive_ff;
   logic         rsp_hit_ff, rsp_pressed_ff;
   logic [7:0]   rsp_char_ff;

   // request decode and handshake
   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !busy && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;
   assign is_tick   = accept && (req_type == REQ_TICK);
   assign is_sample = accept && (req_type == REQ_SAMPLE);
   assign is_pop    = accept && (req_type == REQ_POP);

   kse_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .start_tick     (is_tick),
      .start_sample   (is_sample),
      .rows           (req_rows),
      .busy           (busy),
      .col_drive_next (col_drive_next),
      .push           (push)
   );

   kse_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_go     (is_pop),
      .pop_hit    (pop_hit),
      .rd_pressed (rd_pressed),
      .rd_char    (rd_char)
   );

   // valid bits of the read stage and the output register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // read stage payload, memory data arrives alongside
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_drive_ff <= col_drive_next;
         s1_hit_ff   <= is_pop && pop_hit;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_drive_ff   <= s1_drive_ff;
         rsp_hit_ff     <= s1_hit_ff;
         rsp_pressed_ff <= s1_hit_ff && rd_pressed;
         rsp_char_ff    <= s1_hit_ff ? rd_char : 8'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_col_drive     = rsp_drive_ff;
   assign rsp_pop_valid     = rsp_hit_ff;
   assign rsp_event_pressed = rsp_pressed_ff;
   assign rsp_event_char    = rsp_char_ff;

endmodule
